// ===== src/rmsd_pkg.sv =====
// shared types, codes and defaults for the running mean and standard deviation block
package rmsd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 17;
    localparam int REG_WIDTH        = 16;
    localparam int FIFO_DEPTH_DEF   = 4;

    localparam logic [REG_WIDTH-1:0] GOAL_RESET   = 16'd10;
    localparam logic [REG_WIDTH-1:0] THRESH_RESET = 16'd1280;

    // register indexes
    localparam logic REG_GOAL   = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_CANCEL = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_RUNNING   = 2'd0,
        STAT_SUCCEEDED = 2'd1,
        STAT_ABORTED   = 2'd2,
        STAT_PREEMPTED = 2'd3
    } status_t;

endpackage

// ===== src/running_mean_std_dev.sv =====
// top level of the running mean and standard deviation block
// Running mean and standard deviation over runs of signed Q8.8 samples. The
// front part takes one command word per cycle while its queue has room, keeps
// the count, sum and sum of squares and queues one job per result. The back
// part takes one job at a time: both divisions by the count run together on a
// shift-subtract divider, one bit a cycle over the square-sum width, then the
// mean is squared, the difference formed, and the root is found digit by
// digit. Start and ignored words produce nothing. The result register lets
// the next job start while a word waits on the master side.
module running_mean_std_dev
    import rmsd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int FIFO_DEPTH   = FIFO_DEPTH_DEF,
    localparam int IN_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_F = COUNT_WIDTH + 3 * SAMPLE_WIDTH,
    localparam int OUT_W = ((OUT_F + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    // slave side
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // sample_value
    input  logic [7:0]       s_tuser,   // command
    // master side
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // sample_index, sample_echo, mean_value, std_dev_value
    output logic [7:0]       m_tuser,   // run_status
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int SUM_W = SAMPLE_WIDTH + COUNT_WIDTH - 1;
    localparam int SQ_W  = 2 * SAMPLE_WIDTH + COUNT_WIDTH - 2;
    localparam int JOB_W = 2 + COUNT_WIDTH + SAMPLE_WIDTH + SUM_W + SQ_W;

    logic [REG_WIDTH-1:0] goal_reg, thresh_reg;

    logic             push, pop, full, empty;
    logic [JOB_W-1:0] push_data, pop_data;

    logic [COUNT_WIDTH-1:0]  sample_index;
    logic [SAMPLE_WIDTH-1:0] sample_echo, mean_value, std_dev_value;
    logic [1:0]              run_status;

    // register file, written in the access phase
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg   <= GOAL_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                REG_GOAL:   goal_reg   <= pwdata[REG_WIDTH-1:0];
                REG_THRESH: thresh_reg <= pwdata[REG_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_GOAL:   prdata = {{(32-REG_WIDTH){1'b0}}, goal_reg};
            REG_THRESH: prdata = {{(32-REG_WIDTH){1'b0}}, thresh_reg};
            default:    prdata = '0;
        endcase
    end

    // front: command classification and accumulators
    rmsd_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .command      (s_tuser[1:0]),
        .sample_value (s_tdata[SAMPLE_WIDTH-1:0]),
        .samples_goal (goal_reg),
        .push         (push),
        .push_data    (push_data),
        .full         (full)
    );

    // job queue so either side can stall alone
    rmsd_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    // back: division, square and root
    rmsd_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_data       (pop_data),
        .empty          (empty),
        .pop            (pop),
        .mean_threshold (thresh_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .sample_index   (sample_index),
        .sample_echo    (sample_echo),
        .mean_value     (mean_value),
        .std_dev_value  (std_dev_value),
        .run_status     (run_status)
    );

    // pack the result word, first field lowest
    assign m_tdata = {{(OUT_W-OUT_F){1'b0}}, std_dev_value, mean_value, sample_echo,
                      sample_index};
    assign m_tuser = {6'b0, run_status};
endmodule

// ===== src/rmsd_fifo.sv =====
// small word queue between the front and back parts
module rmsd_fifo
    import rmsd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [ADDR_W:0]  wr_ptr_reg, rd_ptr_reg;

    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign full     = (wr_ptr_reg[ADDR_W] != rd_ptr_reg[ADDR_W])
                   && (wr_ptr_reg[ADDR_W-1:0] == rd_ptr_reg[ADDR_W-1:0]);
    assign pop_data = mem_reg[rd_ptr_reg[ADDR_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg[ADDR_W-1:0]] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end
endmodule

// ===== src/rmsd_front.sv =====
// front part: takes commands, keeps the run accumulators, queues jobs
module rmsd_front
    import rmsd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    localparam int SUM_W = SAMPLE_WIDTH + COUNT_WIDTH - 1,
    localparam int SQ_W  = 2 * SAMPLE_WIDTH + COUNT_WIDTH - 2,
    localparam int JOB_W = 2 + COUNT_WIDTH + SAMPLE_WIDTH + SUM_W + SQ_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              command,
    input  logic [SAMPLE_WIDTH-1:0] sample_value,
    input  logic [REG_WIDTH-1:0]    samples_goal,
    output logic                    push,
    output logic [JOB_W-1:0]        push_data,
    input  logic                    full
);
    typedef struct packed {
        logic                    cancel;
        logic                    last;
        logic [COUNT_WIDTH-1:0]  count;
        logic [SAMPLE_WIDTH-1:0] sample;
        logic [SUM_W-1:0]        sum;
        logic [SQ_W-1:0]         sq;
    } job_t;

    logic                   active_reg, active_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;

    logic                      accept;
    logic [SAMPLE_WIDTH-1:0]   mag;
    logic [2*SAMPLE_WIDTH-1:0] mag_sq;
    logic [COUNT_WIDTH-1:0]    count_inc;
    job_t                      job;

    assign in_ready  = !full;
    assign accept    = in_valid && in_ready;
    assign mag       = sample_value[SAMPLE_WIDTH-1] ? (~sample_value + 1'b1) : sample_value;
    assign mag_sq    = mag * mag;
    assign count_inc = (count_reg == '1) ? count_reg : (count_reg + 1'b1);

    always_comb
    begin
        active_next = active_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        sq_next     = sq_reg;
        push        = 1'b0;
        job         = '0;
        if (accept)
        begin
            unique case (command)
                CMD_START:
                begin
                    active_next = 1'b1;
                    count_next  = '0;
                    sum_next    = '0;
                    sq_next     = '0;
                end
                CMD_CANCEL:
                begin
                    if (active_reg)
                    begin
                        active_next = 1'b0;
                        push        = 1'b1;
                        job.cancel  = 1'b1;
                        job.count   = count_reg;
                    end
                end
                CMD_SAMPLE:
                begin
                    if (active_reg)
                    begin
                        count_next = count_inc;
                        sum_next   = sum_reg + {{(SUM_W-SAMPLE_WIDTH){sample_value[SAMPLE_WIDTH-1]}},
                                                sample_value};
                        sq_next    = sq_reg + {{(SQ_W-2*SAMPLE_WIDTH){1'b0}}, mag_sq};
                        push       = 1'b1;
                        job.last   = (count_inc > samples_goal);
                        job.count  = count_inc;
                        job.sample = sample_value;
                        job.sum    = sum_next;
                        job.sq     = sq_next;
                        if (job.last)
                        begin
                            active_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign push_data = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            count_reg  <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
        end
        else
        begin
            active_reg <= active_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            sq_reg     <= sq_next;
        end
    end
endmodule

// ===== src/rmsd_back.sv =====
// back part: divides, squares and takes the root, then holds the result word
module rmsd_back
    import rmsd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    localparam int SUM_W = SAMPLE_WIDTH + COUNT_WIDTH - 1,
    localparam int SQ_W  = 2 * SAMPLE_WIDTH + COUNT_WIDTH - 2,
    localparam int JOB_W = 2 + COUNT_WIDTH + SAMPLE_WIDTH + SUM_W + SQ_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [JOB_W-1:0]        pop_data,
    input  logic                    empty,
    output logic                    pop,
    input  logic [REG_WIDTH-1:0]    mean_threshold,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [COUNT_WIDTH-1:0]  sample_index,
    output logic [SAMPLE_WIDTH-1:0] sample_echo,
    output logic [SAMPLE_WIDTH-1:0] mean_value,
    output logic [SAMPLE_WIDTH-1:0] std_dev_value,
    output logic [1:0]              run_status
);
    localparam int DIVW   = SQ_W;
    localparam int DIFF_W = 2 * SUM_W;
    localparam int ROOT_W = SUM_W;
    localparam int DSTEP_W = $clog2(DIVW + 1);
    localparam int RSTEP_W = $clog2(ROOT_W + 1);

    typedef struct packed {
        logic                    cancel;
        logic                    last;
        logic [COUNT_WIDTH-1:0]  count;
        logic [SAMPLE_WIDTH-1:0] sample;
        logic [SUM_W-1:0]        sum;
        logic [SQ_W-1:0]         sq;
    } job_t;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_DIV  = 6'b000010,
        B_MUL  = 6'b000100,
        B_SUBT = 6'b001000,
        B_ROOT = 6'b010000,
        B_DONE = 6'b100000
    } back_state_t;

    back_state_t        state_reg;
    job_t               job_reg, job_in;
    logic               neg_reg;
    logic [DIVW-1:0]    num_reg, sqn_reg;
    logic [COUNT_WIDTH-1:0] rem_a_reg, rem_b_reg;
    logic [DSTEP_W-1:0] dstep_reg;
    logic [RSTEP_W-1:0] rstep_reg;
    logic [SUM_W-1:0]   mean_reg;
    logic [DIFF_W-1:0]  msq_reg, x_reg;
    logic [ROOT_W:0]    rrem_reg;
    logic [ROOT_W-1:0]  root_reg;

    logic                   out_valid_reg;
    logic [COUNT_WIDTH-1:0] index_reg;
    logic [SAMPLE_WIDTH-1:0] echo_reg, mean_out_reg, sd_reg;
    logic [1:0]             status_reg;

    logic [COUNT_WIDTH:0]   ra, rb, den;
    logic                   qa, qb;
    logic [SUM_W-1:0]       qmag, abs_sum;
    logic [DIFF_W-1:0]      sq_ext;
    logic [ROOT_W+2:0]      rr, trial;
    logic                   rge;
    logic                   load;
    logic [SAMPLE_WIDTH-1:0] sd_sat;

    assign job_in  = job_t'(pop_data);
    assign pop     = (state_reg == B_IDLE) && !empty;
    assign abs_sum = job_in.sum[SUM_W-1] ? (~job_in.sum + 1'b1) : job_in.sum;

    // one restoring step on both quotients
    assign den = {1'b0, job_reg.count};
    assign ra  = {rem_a_reg, num_reg[DIVW-1]};
    assign rb  = {rem_b_reg, sqn_reg[DIVW-1]};
    assign qa  = (ra >= den);
    assign qb  = (rb >= den);

    assign qmag   = num_reg[SUM_W-1:0];
    assign sq_ext = {{(DIFF_W-SQ_W){1'b0}}, sqn_reg[SQ_W-1:0]};

    // one digit of the square root
    assign rr    = {rrem_reg, x_reg[DIFF_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign rge   = (rr >= trial);

    assign sd_sat = (|root_reg[ROOT_W-1:SAMPLE_WIDTH]) ? '1 : root_reg[SAMPLE_WIDTH-1:0];
    assign load   = (state_reg == B_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                job_reg   <= job_in;
                neg_reg   <= job_in.sum[SUM_W-1];
                num_reg   <= {{(DIVW-SUM_W){1'b0}}, abs_sum};
                sqn_reg   <= job_in.sq;
                rem_a_reg <= '0;
                rem_b_reg <= '0;
            end
            B_DIV:
            begin
                rem_a_reg <= qa ? COUNT_WIDTH'(ra - den) : ra[COUNT_WIDTH-1:0];
                rem_b_reg <= qb ? COUNT_WIDTH'(rb - den) : rb[COUNT_WIDTH-1:0];
                num_reg   <= {num_reg[DIVW-2:0], qa};
                sqn_reg   <= {sqn_reg[DIVW-2:0], qb};
            end
            B_MUL:
            begin
                msq_reg  <= qmag * qmag;
                mean_reg <= neg_reg ? (~qmag + 1'b1) : qmag;
            end
            B_SUBT:
            begin
                x_reg    <= (sq_ext >= msq_reg) ? (sq_ext - msq_reg) : (msq_reg - sq_ext);
                rrem_reg <= '0;
                root_reg <= '0;
            end
            B_ROOT:
            begin
                rrem_reg <= rge ? (ROOT_W+1)'(rr - trial) : rr[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], rge};
                x_reg    <= {x_reg[DIFF_W-3:0], 2'b00};
            end
            B_DONE:
            begin
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            index_reg <= job_reg.count;
            if (job_reg.cancel)
            begin
                echo_reg     <= '0;
                mean_out_reg <= '0;
                sd_reg       <= '0;
                status_reg   <= STAT_PREEMPTED;
            end
            else
            begin
                echo_reg     <= job_reg.sample;
                mean_out_reg <= mean_reg[SAMPLE_WIDTH-1:0];
                sd_reg       <= sd_sat;
                if (!job_reg.last)
                begin
                    status_reg <= STAT_RUNNING;
                end
                else if ($signed(mean_reg) < $signed(mean_threshold))
                begin
                    status_reg <= STAT_ABORTED;
                end
                else
                begin
                    status_reg <= STAT_SUCCEEDED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            dstep_reg     <= '0;
            rstep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    dstep_reg <= '0;
                    if (!empty)
                    begin
                        state_reg <= job_in.cancel ? B_DONE : B_DIV;
                    end
                end
                B_DIV:
                begin
                    dstep_reg <= dstep_reg + 1'b1;
                    if (dstep_reg == DSTEP_W'(DIVW - 1))
                    begin
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    state_reg <= B_SUBT;
                end
                B_SUBT:
                begin
                    rstep_reg <= '0;
                    state_reg <= B_ROOT;
                end
                B_ROOT:
                begin
                    rstep_reg <= rstep_reg + 1'b1;
                    if (rstep_reg == RSTEP_W'(ROOT_W - 1))
                    begin
                        state_reg <= B_DONE;
                    end
                end
                B_DONE:
                begin
                    if (load)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_index  = index_reg;
    assign sample_echo   = echo_reg;
    assign mean_value    = mean_out_reg;
    assign std_dev_value = sd_reg;
    assign run_status    = status_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == B_IDLE))
        else $error("job taken while back part busy");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("finished result not presented");

    a_preempt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STAT_PREEMPTED))
            |-> (echo_reg == '0) && (mean_out_reg == '0) && (sd_reg == '0))
        else $error("preempted word carries statistics");

    a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STAT_PREEMPTED)) |-> (index_reg != '0))
        else $error("sample word with zero index");
endmodule
